### sv/mhfd_pkg.sv
// Shared types, constants and key text for the MJPEG HTTP frame deframer.
package mhfd_pkg;

   localparam int LENGTH_BITS = 24;
   localparam int PROD_BITS = LENGTH_BITS + 4;
   localparam logic [LENGTH_BITS-1:0] MAX_LENGTH = {LENGTH_BITS{1'b1}};

   localparam int KEY_LEN = 16;
   localparam int KEY_IDX_BITS = 4;
   localparam logic [7:0] KEY_TEXT [KEY_LEN] = '{
      8'h43, 8'h6f, 8'h6e, 8'h74, 8'h65, 8'h6e, 8'h74, 8'h2d,
      8'h4c, 8'h65, 8'h6e, 8'h67, 8'h74, 8'h68, 8'h3a, 8'h20
   };

   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] JPEG_MARK = 8'hff;

   localparam logic [1:0] KIND_IMAGE = 2'd0;
   localparam logic [1:0] KIND_DROPPED = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      PH_SEARCH = 4'b0001,
      PH_SPACES = 4'b0010,
      PH_DIGITS = 4'b0100,
      PH_DONE   = 4'b1000
   } len_phase_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] kind;
      logic [7:0] image_byte;
      logic       frame_last;
   } result_type;

endpackage

### sv/mhfd_parser.sv
// Header parser and payload tracker: consumes one byte per step and forms its result.
module mhfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           data,
   output mhfd_pkg::result_type res
);

   logic                                in_payload_ff, in_payload_in;
   logic [1:0]                          end_prog_ff, end_prog_in;
   logic [mhfd_pkg::KEY_IDX_BITS-1:0]   key_prog_ff, key_prog_in;
   mhfd_pkg::len_phase_type             phase_ff, phase_in;
   logic [mhfd_pkg::LENGTH_BITS-1:0]    length_ff, length_in;
   logic [mhfd_pkg::LENGTH_BITS-1:0]    remain_ff, remain_in;
   logic                                strip_ff, strip_in;

   logic                                is_digit;
   logic [3:0]                          digit;
   logic [mhfd_pkg::PROD_BITS-1:0]      prod;
   logic [mhfd_pkg::KEY_IDX_BITS:0]     key_next;
   logic [2:0]                          end_next;
   logic [7:0]                          end_want;
   logic                                last;

   assign is_digit = (data >= mhfd_pkg::CHAR_ZERO) && (data <= mhfd_pkg::CHAR_NINE);
   assign digit = 4'(data - mhfd_pkg::CHAR_ZERO);
   assign prod = ({4'b0, length_ff} << 3) + ({4'b0, length_ff} << 1)
                 + mhfd_pkg::PROD_BITS'(digit);
   assign end_want = end_prog_ff[0] ? mhfd_pkg::CHAR_LF : mhfd_pkg::CHAR_CR;

   always_comb begin
      in_payload_in = in_payload_ff;
      end_prog_in = end_prog_ff;
      key_prog_in = key_prog_ff;
      phase_in = phase_ff;
      length_in = length_ff;
      remain_in = remain_ff;
      strip_in = strip_ff;
      key_next = '0;
      end_next = '0;
      last = 1'b0;
      res = '0;

      if (in_payload_ff) begin
         remain_in = remain_ff - 1'b1;
         last = (remain_in == '0);
         if (last) begin
            in_payload_in = 1'b0;
            end_prog_in = '0;
            key_prog_in = '0;
            phase_in = mhfd_pkg::PH_SEARCH;
            length_in = '0;
         end
         if (strip_ff && (data != mhfd_pkg::JPEG_MARK)) begin
            if (last) begin
               res.valid = 1'b1;
               res.kind = mhfd_pkg::KIND_EMPTY;
               res.frame_last = 1'b1;
            end
         end else begin
            strip_in = 1'b0;
            res.valid = 1'b1;
            res.kind = mhfd_pkg::KIND_IMAGE;
            res.image_byte = data;
            res.frame_last = last;
         end
      end else begin
         unique case (phase_ff)
            mhfd_pkg::PH_SEARCH: begin
               if (data == mhfd_pkg::KEY_TEXT[key_prog_ff]) begin
                  key_next = {1'b0, key_prog_ff} + 1'b1;
               end else if (data == mhfd_pkg::KEY_TEXT[0]) begin
                  key_next = (mhfd_pkg::KEY_IDX_BITS+1)'(1);
               end else begin
                  key_next = '0;
               end
               if (key_next[mhfd_pkg::KEY_IDX_BITS]) begin
                  phase_in = mhfd_pkg::PH_SPACES;
                  length_in = '0;
                  key_prog_in = '0;
               end else begin
                  key_prog_in = key_next[mhfd_pkg::KEY_IDX_BITS-1:0];
               end
            end
            mhfd_pkg::PH_SPACES: begin
               if (is_digit) begin
                  length_in = mhfd_pkg::LENGTH_BITS'(digit);
                  phase_in = mhfd_pkg::PH_DIGITS;
               end else if (data != mhfd_pkg::CHAR_SPACE) begin
                  phase_in = mhfd_pkg::PH_DONE;
               end
            end
            mhfd_pkg::PH_DIGITS: begin
               if (is_digit) begin
                  if (prod > {4'b0, mhfd_pkg::MAX_LENGTH}) begin
                     length_in = mhfd_pkg::MAX_LENGTH;
                  end else begin
                     length_in = prod[mhfd_pkg::LENGTH_BITS-1:0];
                  end
               end else begin
                  phase_in = mhfd_pkg::PH_DONE;
               end
            end
            mhfd_pkg::PH_DONE: begin
            end
            default: begin
               phase_in = mhfd_pkg::PH_SEARCH;
            end
         endcase

         if (data == end_want) begin
            end_next = {1'b0, end_prog_ff} + 1'b1;
         end else if (data == mhfd_pkg::CHAR_CR) begin
            end_next = 3'd1;
         end else begin
            end_next = 3'd0;
         end

         if (!end_next[2]) begin
            end_prog_in = end_next[1:0];
         end else begin
            if (phase_in == mhfd_pkg::PH_SEARCH) begin
               res.valid = 1'b1;
               res.kind = mhfd_pkg::KIND_DROPPED;
               res.frame_last = 1'b1;
            end else begin
               remain_in = length_in;
               strip_in = 1'b1;
               if (length_in == '0) begin
                  res.valid = 1'b1;
                  res.kind = mhfd_pkg::KIND_EMPTY;
                  res.frame_last = 1'b1;
               end else begin
                  in_payload_in = 1'b1;
               end
            end
            end_prog_in = '0;
            key_prog_in = '0;
            phase_in = mhfd_pkg::PH_SEARCH;
            length_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_payload_ff <= 1'b0;
         end_prog_ff <= '0;
         key_prog_ff <= '0;
         phase_ff <= mhfd_pkg::PH_SEARCH;
         length_ff <= '0;
         remain_ff <= '0;
         strip_ff <= 1'b1;
      end else if (step) begin
         in_payload_ff <= in_payload_in;
         end_prog_ff <= end_prog_in;
         key_prog_ff <= key_prog_in;
         phase_ff <= phase_in;
         length_ff <= length_in;
         remain_ff <= remain_in;
         strip_ff <= strip_in;
      end
   end

`ifndef ASSERT_OFF
   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (remain_ff != '0))
      else $error("Payload phase entered with no bytes remaining.");

   a_payload_header_clear: assert property (@(posedge clock) disable iff (reset)
      in_payload_ff |-> (key_prog_ff == '0 && end_prog_ff == '0 && length_ff == '0))
      else $error("Header match state not cleared during payload.");

   a_frame_end_leaves_payload: assert property (@(posedge clock) disable iff (reset)
      (step && res.valid && res.frame_last && in_payload_ff) |=> !in_payload_ff)
      else $error("Final payload result did not return to header phase.");
`endif

endmodule

### sv/mjpeg_http_frame_deframer_core.sv
// Top level of the MJPEG HTTP frame deframer: input register, parser and result register.
//
//   Channel  Direction  Signals                                  Transaction
//   req      in         req_valid, req_ready, req_stream_byte    one raw stream byte
//   rsp      out        rsp_valid, rsp_ready, rsp_kind,          zero or one result per byte
//                       rsp_image_byte, rsp_frame_last
//
// Each byte passes through an input register and leaves its result, if any, in the output
// register, so one byte is taken every cycle while results drain.
// The parser state advances only when the byte in the input register moves on.
// A stalled result register holds the input register, which takes a byte only while empty.
// Reset is synchronous and returns the parser to header phase with no frame open.
module mjpeg_http_frame_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_image_byte,
   output logic       rsp_frame_last
);

   logic                 in_valid_ff, in_valid_in;
   logic [7:0]           in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           out_kind_ff;
   logic [7:0]           out_byte_ff;
   logic                 out_last_ff;
   logic                 advance;
   logic                 step;
   mhfd_pkg::result_type res;

   assign advance = !out_valid_ff || rsp_ready;
   assign step = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   mhfd_parser u_parser (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .data  (in_byte_ff),
      .res   (res)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = step && res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_stream_byte;
      end
      if (advance) begin
         out_kind_ff <= res.kind;
         out_byte_ff <= res.image_byte;
         out_last_ff <= res.frame_last;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind = out_kind_ff;
   assign rsp_image_byte = out_byte_ff;
   assign rsp_frame_last = out_last_ff;

`ifndef ASSERT_OFF
   a_status_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff != mhfd_pkg::KIND_IMAGE) |-> out_last_ff)
      else $error("Dropped or empty frame result without the last mark.");

   a_status_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff != mhfd_pkg::KIND_IMAGE) |-> (out_byte_ff == '0))
      else $error("Dropped or empty frame result carries a nonzero byte.");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("Input register changed while the result register was stalled.");
`endif

endmodule

### tb/tb_mjpeg_http_frame_deframer_core.sv
// Self-checking testbench for the MJPEG HTTP frame deframer core.
module tb_mjpeg_http_frame_deframer_core;

   localparam int IDLE_LIMIT = 3000;
   localparam int RANDOM_BYTES = 450;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] image_byte;
      logic       frame_last;
   } deframe_result_type;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_SPARSE,
      RX_PERIODIC,
      RX_CHOPPY
   } rx_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_stream_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_image_byte;
   logic       rsp_frame_last;

   deframe_result_type frame_results_due[$];

   logic                             in_payload;
   logic [2:0]                       crlf_seen;
   logic [4:0]                       key_seen;
   mhfd_pkg::len_phase_type          number_phase;
   logic [mhfd_pkg::LENGTH_BITS-1:0] parsed_length;
   logic [mhfd_pkg::LENGTH_BITS-1:0] payload_left;
   logic                             strip_prefix;

   int mismatches = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   int bytes_sent = 0;
   rx_mode_type rx_mode = RX_OPEN;
   int rx_hold = 0;

   mjpeg_http_frame_deframer_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_stream_byte(req_stream_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_kind(rsp_kind),
      .rsp_image_byte(rsp_image_byte),
      .rsp_frame_last(rsp_frame_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_header_state();
      crlf_seen = '0;
      key_seen = '0;
      number_phase = mhfd_pkg::PH_SEARCH;
      parsed_length = '0;
   endfunction

   function automatic void reset_deframer_state();
      in_payload = 1'b0;
      clear_header_state();
      payload_left = '0;
      strip_prefix = 1'b1;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b,
                                       output deframe_result_type res);
      logic [mhfd_pkg::PROD_BITS-1:0] prod;
      logic [4:0]                     k;
      logic [2:0]                     e;
      logic [7:0]                     want;
      logic                           last;
      bit                             is_digit;
      res = '{mhfd_pkg::KIND_IMAGE, 8'h00, 1'b0};
      is_digit = (b >= mhfd_pkg::CHAR_ZERO) && (b <= mhfd_pkg::CHAR_NINE);
      if (in_payload) begin
         payload_left = payload_left - 1'b1;
         last = (payload_left == '0);
         if (last) begin
            in_payload = 1'b0;
            clear_header_state();
         end
         if (strip_prefix && b != mhfd_pkg::JPEG_MARK) begin
            if (last) begin
               res = '{mhfd_pkg::KIND_EMPTY, 8'h00, 1'b1};
               return 1'b1;
            end
            return 1'b0;
         end
         strip_prefix = 1'b0;
         res = '{mhfd_pkg::KIND_IMAGE, b, last};
         return 1'b1;
      end
      case (number_phase)
         mhfd_pkg::PH_SPACES: begin
            if (is_digit) begin
               parsed_length = mhfd_pkg::LENGTH_BITS'(b - mhfd_pkg::CHAR_ZERO);
               number_phase = mhfd_pkg::PH_DIGITS;
            end else if (b != mhfd_pkg::CHAR_SPACE) begin
               number_phase = mhfd_pkg::PH_DONE;
            end
         end
         mhfd_pkg::PH_DIGITS: begin
            if (is_digit) begin
               prod = mhfd_pkg::PROD_BITS'(parsed_length) * mhfd_pkg::PROD_BITS'(10)
                      + mhfd_pkg::PROD_BITS'(b - mhfd_pkg::CHAR_ZERO);
               parsed_length = (prod > mhfd_pkg::PROD_BITS'(mhfd_pkg::MAX_LENGTH))
                               ? mhfd_pkg::MAX_LENGTH
                               : prod[mhfd_pkg::LENGTH_BITS-1:0];
            end else begin
               number_phase = mhfd_pkg::PH_DONE;
            end
         end
         default: ;
      endcase
      if (number_phase == mhfd_pkg::PH_SEARCH) begin
         k = key_seen;
         if (k >= mhfd_pkg::KEY_LEN) k = '0;
         if (b == mhfd_pkg::KEY_TEXT[k[3:0]]) k = k + 1'b1;
         else k = (b == mhfd_pkg::KEY_TEXT[0]) ? 5'd1 : 5'd0;
         if (k >= mhfd_pkg::KEY_LEN) begin
            number_phase = mhfd_pkg::PH_SPACES;
            parsed_length = '0;
            k = '0;
         end
         key_seen = k;
      end
      e = {1'b0, crlf_seen[1:0]};
      want = e[0] ? mhfd_pkg::CHAR_LF : mhfd_pkg::CHAR_CR;
      if (b == want) e = e + 1'b1;
      else e = (b == mhfd_pkg::CHAR_CR) ? 3'd1 : 3'd0;
      if (e < 3'd4) begin
         crlf_seen = e;
         return 1'b0;
      end
      if (number_phase == mhfd_pkg::PH_SEARCH) begin
         clear_header_state();
         res = '{mhfd_pkg::KIND_DROPPED, 8'h00, 1'b1};
         return 1'b1;
      end
      payload_left = parsed_length;
      clear_header_state();
      strip_prefix = 1'b1;
      if (payload_left == '0) begin
         res = '{mhfd_pkg::KIND_EMPTY, 8'h00, 1'b1};
         return 1'b1;
      end
      in_payload = 1'b1;
      return 1'b0;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      deframe_result_type res;
      int gap;
      bit taken;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_stream_byte <= b;
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      if (deframe_byte(b, res)) frame_results_due.push_back(res);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic send_key();
      for (int i = 0; i < mhfd_pkg::KEY_LEN; i++) send_byte(mhfd_pkg::KEY_TEXT[i]);
   endtask

   task automatic send_length_header(input int unsigned len);
      send_key();
      send_text($sformatf("%0d\r\n\r\n", len));
   endtask

   task automatic send_random_line();
      int n;
      n = $urandom_range(0, 12);
      send_text("X-");
      repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7e)));
      send_text("\r\n");
   endtask

   task automatic send_jpeg_payload(input int len);
      int prefix;
      prefix = ($urandom_range(0, 9) == 0) ? len
                                           : $urandom_range(0, (len < 3) ? len : 3);
      for (int i = 0; i < len; i++) begin
         if (i < prefix) send_byte(8'($urandom_range(0, 254)));
         else if (i == prefix) send_byte(mhfd_pkg::JPEG_MARK);
         else send_byte(8'($urandom_range(0, 255)));
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (frame_results_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_image_frame();
      send_text("HTTP/1.0 200 OK\r\n");
      send_length_header(6);
      send_byte(mhfd_pkg::JPEG_MARK);
      send_byte(8'hd8);
      send_byte(8'h00);
      send_byte(8'h80);
      send_byte(8'h7f);
      send_byte(8'hd9);
   endtask

   task automatic test_prefix_stripping();
      send_key();
      send_text("  7\r\n\r\n");
      send_byte(8'h00);
      send_byte(mhfd_pkg::CHAR_CR);
      send_byte(mhfd_pkg::CHAR_LF);
      send_byte(mhfd_pkg::JPEG_MARK);
      send_byte(8'h12);
      send_byte(mhfd_pkg::JPEG_MARK);
      send_byte(8'hd9);
      send_length_header(3);
      send_byte(8'h01);
      send_byte(8'h02);
      send_byte(8'hfe);
   endtask

   task automatic test_missing_length();
      send_text("Content-Type: image/jpeg\r\n");
      send_byte(8'h00);
      send_text("\r\n\r\n");
      send_text("content-length: 5\r\n\r\n");
   endtask

   task automatic test_empty_frames();
      send_length_header(0);
      send_key();
      send_text("x\r\n\r\n");
      send_key();
      send_text("-5\r\n\r\n");
      send_key();
      send_text("+5\r\n\r\n");
   endtask

   task automatic test_repeated_key();
      send_key();
      send_text("2\r\n");
      send_length_header(9);
      send_byte(mhfd_pkg::JPEG_MARK);
      send_byte(mhfd_pkg::JPEG_MARK);
   endtask

   task automatic test_key_matching();
      send_text("CC");
      send_key();
      send_text("1\r\r\n\r\n");
      send_byte(mhfd_pkg::JPEG_MARK);
   endtask

   task automatic test_drain_pause();
      send_length_header(2);
      send_byte(mhfd_pkg::JPEG_MARK);
      send_byte(8'haa);
      wait_for_drain();
      send_length_header(1);
      send_byte(8'h55);
   endtask

   task automatic test_random_stream();
      int start;
      int sel;
      int len;
      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         sel = $urandom_range(0, 99);
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(0, 24);
         if (sel < 70) begin
            repeat ($urandom_range(0, 2)) send_random_line();
            send_key();
            repeat ($urandom_range(0, 2)) send_byte(mhfd_pkg::CHAR_SPACE);
            repeat ($urandom_range(0, 2)) send_byte(mhfd_pkg::CHAR_ZERO);
            send_text($sformatf("%0d\r\n", len));
            repeat ($urandom_range(0, 2)) send_random_line();
            send_text("\r\n");
            send_jpeg_payload(len);
         end else if (sel < 85) begin
            repeat ($urandom_range(0, 3)) send_random_line();
            send_text("\r\n");
         end else if (sel < 95) begin
            case ($urandom_range(0, 3))
               0: begin
                  for (int i = 0; i < 11; i++) send_byte(mhfd_pkg::KEY_TEXT[i]);
                  send_text(": 5\r\n\r\n");
               end
               1: begin
                  send_key();
                  send_text($sformatf("-%0d\r\n\r\n", len));
               end
               2: begin
                  send_text("content-length: ");
                  send_text($sformatf("%0d\r\n\r\n", len));
               end
               default: begin
                  send_key();
                  send_text($sformatf("%0d\r\n", $urandom_range(0, 6)));
               end
            endcase
         end else begin
            repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   task automatic test_saturated_length();
      send_key();
      send_text("0016777221999\r\n\r\n");
      send_byte(8'h3c);
      send_byte(mhfd_pkg::JPEG_MARK);
      repeat (60) send_byte(8'($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin
      if (rx_hold == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_hold = $urandom_range(20, 200);
      end else begin
         rx_hold--;
      end
      case (rx_mode)
         RX_OPEN:     rsp_ready <= 1'b1;
         RX_SPARSE:   rsp_ready <= ($urandom_range(0, 4) == 0);
         RX_PERIODIC: rsp_ready <= (rx_hold % 4 != 0);
         default:     rsp_ready <= 1'($urandom_range(0, 1));
      endcase
   end

   always @(negedge clock) begin
      deframe_result_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            if (frame_results_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d byte %02h last %0d",
                           rsp_kind, rsp_image_byte, rsp_frame_last);
            end else begin
               want = frame_results_due.pop_front();
               if (rsp_kind !== want.kind || rsp_image_byte !== want.image_byte ||
                   rsp_frame_last !== want.frame_last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: expected kind %0d byte %02h last %0d, ",
                               "got kind %0d byte %02h last %0d"},
                              want.kind, want.image_byte, want.frame_last,
                              rsp_kind, rsp_image_byte, rsp_frame_last);
               end
            end
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(negedge clock);
      $display("Verification failed");
      $finish;
   end

   initial begin
      reset_deframer_state();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_image_frame();
      test_prefix_stripping();
      test_missing_length();
      test_empty_frames();
      test_repeated_key();
      test_key_matching();
      test_drain_pause();
      test_random_stream();
      test_saturated_length();
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && frame_results_due.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
